// ----- design/rolling_average_pressure_top_defines.svh -----
// Assertion macros shared by the rolling average pressure design.
// Both macros expect signals named clk and rst in the module that uses them.
`ifndef ROLLING_AVERAGE_PRESSURE_TOP_DEFINES_SVH
`define ROLLING_AVERAGE_PRESSURE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define RAP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rolling average pressure: assertion failed");

// Next-cycle implication.
`define RAP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rolling average pressure: assertion failed");

`else

`define RAP_ASSERT_IMPL(label, ante, cons)
`define RAP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/rap_pkg.sv -----
package rap_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int MAX_WINDOW = 32;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 6;
  localparam int SUM_W      = 17;
  localparam int SUB_W      = SAMPLE_W + WIN_W;

  // Gain ratio A/B = 625000 / K7, reduced, per sensor range.
  localparam int GAIN_NUM_W = 19;
  localparam int GAIN_DEN_W = 13;
  localparam int NB_W       = 18;
  localparam int PROD_W     = SUM_W + GAIN_NUM_W;
  localparam int NUM_W      = PROD_W + 1;
  localparam int DEN_W      = NB_W + 1;
  localparam int QUOT_W     = 20;
  localparam int P_W        = 19;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd8;

  localparam logic [1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [1:0] REG_OFFSET_COUNTS = 2'd1;
  localparam logic [1:0] REG_DEVICE_TYPE   = 2'd2;

  localparam logic [1:0] DEV_10KPA  = 2'd0;
  localparam logic [1:0] DEV_100KPA = 2'd1;
  localparam logic [1:0] DEV_700KPA = 2'd2;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_status_t;

  function automatic logic [GAIN_NUM_W-1:0] gain_num(input logic [1:0] dev);
    logic [GAIN_NUM_W-1:0] g;
    unique case (dev)
      DEV_10KPA:  g = 19'd25;
      DEV_100KPA: g = 19'd125;
      default:    g = 19'd312500;
    endcase
    return g;
  endfunction

  function automatic logic [GAIN_DEN_W-1:0] gain_den(input logic [1:0] dev);
    logic [GAIN_DEN_W-1:0] g;
    unique case (dev)
      DEV_10KPA:  g = 13'd36;
      DEV_100KPA: g = 13'd18;
      default:    g = 13'd6429;
    endcase
    return g;
  endfunction

endpackage

// ----- design/rolling_average_pressure_top.sv -----
// Rolling average pressure converter. Each input item carries one 12-bit
// converter sample; each item yields exactly one result item holding the
// pressure in kPa as a signed Q8 value, saturated to 19 bits, and a flag
// that is set once the window is full. Until then the
// average covers only the samples received so far. Writing window_size
// restarts averaging with the next sample; offset_counts and device_type
// take effect on the next item. Configuration may be written only while
// the block is idle. An accepted item passes in order through the ring
// memory read, the update and scaling arithmetic, the bit-serial
// divider that forms the rounded quotient, and the load of the output
// register. Items are processed one at a time; a finished result waits
// in the output register while the next item is taken in, and the block
// stalls only if a second result is ready before the first has been taken.
`include "rolling_average_pressure_top_defines.svh"

module rolling_average_pressure_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [rap_pkg::SAMPLE_W-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rap_pkg::SAMPLE_W-1:0] adc_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [rap_pkg::P_W-1:0] pressure_q8,
  output logic                         window_full
);
  import rap_pkg::*;

  // Sequencer codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_MAG   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_NUM   = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [QUOT_W-1:0] Q_POS_LIM = 20'd262143;
  localparam logic [QUOT_W-1:0] Q_NEG_LIM = 20'd262144;
  localparam logic [P_W-1:0]    P_MAX_V   = 19'h3FFFF;
  localparam logic [P_W-1:0]    P_MIN_V   = 19'h40000;

  logic [2:0] state;

  // Configuration registers.
  logic [WIN_W-1:0]    window_size;
  logic [SAMPLE_W-1:0] offset_counts;
  logic [1:0]          device_type;
  logic [WIN_W-1:0]    eff_w;

  // Window bookkeeping.
  logic [RING_AW-1:0]  write_pos;
  logic [WIN_W-1:0]    fill_count;
  logic [SUM_W-1:0]    running_sum;

  // Per-item working registers.
  logic [RING_AW-1:0]  pos;
  logic [SAMPLE_W-1:0] sample;
  logic [SUB_W-1:0]    sub_r;
  logic [NB_W-1:0]     nb_r;
  logic                full_r;
  logic [SUM_W-1:0]    mag_r;
  logic                neg_r;
  logic [PROD_W-1:0]   prod_r;

  logic                accept;
  logic [RING_AW-1:0]  pos_cur;
  logic [SAMPLE_W-1:0] rd_data;
  logic                full_before;
  logic [SUM_W:0]      sum_wide;
  logic [RING_AW:0]    pos_inc;
  logic [SUB_W-1:0]    sub_prod;
  logic [WIN_W+GAIN_DEN_W-1:0] nb_prod;
  logic [SUB_W-1:0]    sum_ext;
  logic [SUB_W-1:0]    mag_diff;
  logic [PROD_W-1:0]   prod_full;
  logic [NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  div_status_t         div_st;
  logic                out_free;
  logic [P_W-1:0]      p_sat;

  // A window size of zero acts as one; sizes beyond the ring saturate.
  always_comb begin
    if (window_size == '0) begin
      eff_w = WIN_W'(1);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      eff_w = WIN_W'(MAX_WINDOW);
    end else begin
      eff_w = window_size;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Slot for the new sample; the oldest sample sits there once full.
  assign pos_cur     = ({1'b0, write_pos} >= eff_w) ? '0 : write_pos;
  assign full_before = (fill_count >= eff_w);
  assign sum_wide    = {1'b0, running_sum} + (SUM_W+1)'(sample)
                       - (full_before ? (SUM_W+1)'(rd_data) : '0);
  assign pos_inc     = {1'b0, pos} + 1'b1;

  assign sub_prod  = offset_counts * fill_count;
  assign nb_prod   = fill_count * gain_den(device_type);
  assign sum_ext   = {1'b0, running_sum};
  assign mag_diff  = (sum_ext >= sub_r) ? (sum_ext - sub_r) : (sub_r - sum_ext);
  assign prod_full = mag_r * gain_num(device_type);

  // Rounded quotient: (2*mag*A + n*B) / (2*n*B).
  assign div_num = {prod_r, 1'b0} + NUM_W'(nb_r);
  assign div_den = {nb_r, 1'b0};

  rap_ring u_ring (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos_cur),
    .rd_data (rd_data),
    .wr_en   (state == S_UPD),
    .wr_addr (pos),
    .wr_data (sample)
  );

  rap_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (state == S_NUM),
    .num    (div_num),
    .den    (div_den),
    .status (div_st)
  );

  // Saturate the magnitude and apply the sign.
  always_comb begin
    if (neg_r) begin
      if (div_st.quot > Q_NEG_LIM) begin
        p_sat = P_MIN_V;
      end else begin
        p_sat = P_W'(~div_st.quot + 1'b1);
      end
    end else begin
      if (div_st.quot > Q_POS_LIM) begin
        p_sat = P_MAX_V;
      end else begin
        p_sat = div_st.quot[P_W-1:0];
      end
    end
  end

  // Configuration writes and window bookkeeping share one process, since
  // a window size write clears the window state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      offset_counts <= '0;
      device_type   <= DEV_10KPA;
      write_pos     <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_SIZE: begin
            window_size <= cfg_data[WIN_W-1:0];
            write_pos   <= '0;
            fill_count  <= '0;
            running_sum <= '0;
          end
          REG_OFFSET_COUNTS: offset_counts <= cfg_data;
          REG_DEVICE_TYPE:   device_type   <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (state == S_UPD) begin
        if (!full_before) begin
          fill_count <= fill_count + 1'b1;
        end
        running_sum <= sum_wide[SUM_W-1:0];
        write_pos   <= (pos_inc >= eff_w) ? '0 : pos_inc[RING_AW-1:0];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (accept) state <= S_UPD;
        S_UPD:   state <= S_SCALE;
        S_SCALE: state <= S_MAG;
        S_MAG:   state <= S_MUL;
        S_MUL:   state <= S_NUM;
        S_NUM:   state <= S_DIV;
        S_DIV:   if (div_st.done) state <= S_DONE;
        S_DONE:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      pos    <= pos_cur;
      sample <= adc_sample;
    end
    if (state == S_SCALE) begin
      sub_r  <= sub_prod;
      nb_r   <= nb_prod[NB_W-1:0];
      full_r <= full_before;
    end
    if (state == S_MAG) begin
      mag_r <= mag_diff[SUM_W-1:0];
      neg_r <= (sum_ext < sub_r);
    end
    if (state == S_MUL) begin
      prod_r <= prod_full;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      pressure_q8 <= p_sat;
      window_full <= full_r;
    end
  end

  `RAP_ASSERT_IMPL(a_fill_in_window, 1'b1, fill_count <= eff_w)
  `RAP_ASSERT_IMPL(a_pos_in_window, 1'b1, {1'b0, write_pos} < eff_w)
  `RAP_ASSERT_NEXT(a_accept_to_update, accept, state == S_UPD)
  `RAP_ASSERT_NEXT(a_div_started, state == S_NUM, div_st.busy)
  `RAP_ASSERT_NEXT(a_result_held, state == S_DONE && !out_free, state == S_DONE)

endmodule

// ----- design/rap_ring.sv -----
module rap_ring (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [rap_pkg::RING_AW-1:0]  rd_addr,
  output logic [rap_pkg::SAMPLE_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [rap_pkg::RING_AW-1:0]  wr_addr,
  input  logic [rap_pkg::SAMPLE_W-1:0] wr_data
);
  import rap_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/rap_div.sv -----
module rap_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rap_pkg::NUM_W-1:0] num,
  input  logic [rap_pkg::DEN_W-1:0] den,
  output rap_pkg::div_status_t      status
);
  import rap_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_sh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [QUOT_W-1:0] quot;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, num_sh[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      rem    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quot   <= {quot[QUOT_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.quot = quot;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import rap_pkg::*;

  // The converter scales by FULL_SCALE counts and by a per-range transfer
  // constant held as an integer times 10^7.
  localparam longint unsigned FULL_SCALE  = 4096;
  localparam longint unsigned K7_10KPA    = 900000;
  localparam longint unsigned K7_100KPA   = 90000;
  localparam longint unsigned K7_700KPA   = 12858;
  localparam longint unsigned Q8_SCALE    = 256 * 64'd10000000;
  localparam logic signed [P_W-1:0] PRESSURE_MIN = {1'b1, {(P_W-1){1'b0}}};
  localparam logic signed [P_W-1:0] PRESSURE_MAX = {1'b0, {(P_W-1){1'b1}}};

  // Leave slack after the last result before touching a register or
  // ending the run.
  localparam int IDLE_SLACK    = 8;
  localparam int END_SLACK     = 60;
  localparam int SAMPLE_TARGET = 1800;
  localparam int CYCLE_LIMIT   = 1500000;

  typedef struct {
    logic signed [P_W-1:0] pressure;
    logic                  full;
  } reading_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [1:0]            cfg_index = REG_WINDOW_SIZE;
  logic [SAMPLE_W-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   adc_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [P_W-1:0] pressure_q8;
  logic                  window_full;

  rolling_average_pressure_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .adc_sample  (adc_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pressure_q8 (pressure_q8),
    .window_full (window_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the converter: its registers, its ring of samples and
  // the running state of the rolling window.
  logic [WIN_W-1:0]    cur_window = WINDOW_RESET;
  logic [SAMPLE_W-1:0] cur_offset = '0;
  logic [1:0]          cur_device = DEV_10KPA;
  logic [SAMPLE_W-1:0] ring_copy [MAX_WINDOW];
  int unsigned         next_slot = 0;
  int unsigned         samples_held = 0;
  int unsigned         window_sum = 0;

  reading_t pending_readings [$];
  int       error_count = 0;
  int       samples_sent = 0;
  int       readings_checked = 0;
  int       config_writes = 0;

  // Watchdog. Even with the longest receiver stalls and sender gaps the run
  // needs only a fraction of this.
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d readings outstanding", pending_readings.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic longint unsigned range_k7(input logic [1:0] dev);
    case (dev)
      DEV_10KPA:  return K7_10KPA;
      DEV_100KPA: return K7_100KPA;
      default:    return K7_700KPA;   // Device type three reads as 700 kPa.
    endcase
  endfunction

  // Advances the shadow window by one sample and returns the pressure that
  // the block must report for it.
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    int unsigned       w;
    int unsigned       pos;
    longint unsigned   sub;
    longint unsigned   mag;
    longint unsigned   den;
    longint unsigned   q;
    bit                neg;
    reading_t          r;
    w = (cur_window == 0) ? 1 : ((cur_window > MAX_WINDOW) ? MAX_WINDOW : cur_window);
    pos = (next_slot >= w) ? 0 : next_slot;
    // Once the window is full the oldest sample drops out of the sum.
    if (samples_held < w) samples_held++;
    else window_sum -= ring_copy[pos];
    ring_copy[pos] = s;
    window_sum += s;
    pos++;
    next_slot = (pos >= w) ? 0 : pos;

    // Sign and magnitude of (sum - offset * n), then a rounded divide with
    // ties away from zero.
    sub = longint'(cur_offset) * samples_held;
    neg = (longint'(window_sum) < sub);
    mag = neg ? sub - window_sum : window_sum - sub;
    mag = mag * Q8_SCALE;
    den = longint'(samples_held) * FULL_SCALE * range_k7(cur_device);
    q = (2 * mag + den) / (2 * den);
    if (neg) r.pressure = (q > 64'd262144) ? PRESSURE_MIN : P_W'(-longint'(q));
    else     r.pressure = (q > 64'd262143) ? PRESSURE_MAX : P_W'(q);
    r.full = (samples_held >= w);
    return r;
  endfunction

  // Result checker: every accepted result item is matched against the
  // oldest reading still outstanding. Sampling at the rising edge sees the
  // values from before the edge, and out_ready only moves on falling edges.
  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("result item with no reading outstanding: pressure_q8 %0d", pressure_q8);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (pressure_q8 !== want.pressure) begin
          $error("pressure_q8 mismatch: expected %0d, actual %0d", want.pressure, pressure_q8);
          error_count++;
        end
        if (window_full !== want.full) begin
          $error("window_full mismatch: expected %0b, actual %0b", want.full, window_full);
          error_count++;
        end
      end
    end
  end

  // Receiver back-pressure. It switches between long relaxed stretches
  // with no stalls at all and stretches of random stalls; some stalls are
  // long enough that a second result backs up inside the block.
  int  rx_hold = 0;
  int  rx_mode_left = 0;
  bit  rx_relaxed = 1'b0;
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_relaxed = ($urandom_range(0, 3) == 0);
      rx_mode_left = $urandom_range(200, 2000);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else if (!rx_relaxed && $urandom_range(0, 5) == 0) begin
      rx_hold = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 120 : 30);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one sample and holds it until the block takes it. Called on a
  // falling edge, returns on a falling edge with in_valid still high, so a
  // following item can go out back to back.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    adc_sample <= s;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(predict_reading(s));
    samples_sent++;
    @(negedge clk);
  endtask

  // Sender gap: valid drops and the data bus carries junk meanwhile.
  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      adc_sample <= SAMPLE_W'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  // Waits until every outstanding reading has come back, then a few more
  // cycles, so that a register can be written with the block idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (IDLE_SLACK) @(negedge clk);
  endtask

  // One register write; the shadow copy takes the same masked value.
  task automatic write_reg(input logic [1:0] index, input logic [SAMPLE_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (index)
      REG_WINDOW_SIZE: begin
        cur_window = data[WIN_W-1:0];
        next_slot = 0;
        samples_held = 0;
        window_sum = 0;
      end
      REG_OFFSET_COUNTS: cur_offset = data;
      REG_DEVICE_TYPE:   cur_device = data[1:0];
      default: ;
    endcase
    config_writes++;
    @(negedge clk);
  endtask

  // Warm-up at the reset settings: the average covers only the samples so
  // far, then the window of eight fills and wraps around.
  task automatic test_warmup_at_reset();
    logic [SAMPLE_W-1:0] seq [10] = '{12'd0, 12'd4095, 12'd4095, 12'd100, 12'd2048,
                                      12'd1, 12'd4094, 12'd4095, 12'd0, 12'd3000};
    foreach (seq[i]) begin
      send_sample(seq[i]);
      if (i % 3 == 2) pause_sender(i);
    end
  endtask

  // Extremes of sample and offset under every sensor range, including the
  // spare device code that must act as the 700 kPa range.
  task automatic test_range_extremes();
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 12'd1);
    write_reg(REG_OFFSET_COUNTS, 12'd4095);
    write_reg(REG_DEVICE_TYPE, {10'h3FF, DEV_700KPA});
    send_sample(12'd0);      // Most negative pressure the block can produce.
    send_sample(12'd4095);   // Sample equal to the offset: zero.
    wait_idle();
    write_reg(REG_OFFSET_COUNTS, 12'd0);
    send_sample(12'd4095);   // Most positive pressure.
    wait_idle();
    write_reg(REG_DEVICE_TYPE, 12'd3);
    send_sample(12'd4095);
    wait_idle();
    write_reg(REG_DEVICE_TYPE, {10'd0, DEV_10KPA});
    send_sample(12'd4095);
    wait_idle();
    write_reg(REG_DEVICE_TYPE, {10'd0, DEV_100KPA});
    send_sample(12'd2049);
  endtask

  // Window of zero acts as one, a window above the maximum saturates, and
  // rewriting the window part way through a fill restarts the average.
  task automatic test_window_specials();
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 12'd0);
    send_sample(12'd123);
    send_sample(12'd4000);
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 12'hFFF);   // Low six bits are 63.
    send_sample(12'd4095);
    send_sample(12'd17);
    send_sample(12'd2500);
    wait_idle();
    write_reg(REG_WINDOW_SIZE, 12'd3);
    send_sample(12'd1000);
    send_sample(12'd1001);
    send_sample(12'd3999);
    send_sample(12'd5);
  endtask

  // Sensor-like samples: half of them uniform, with slow drift around the
  // previous value, readings close to the offset and the rails.
  function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] prev);
    int v;
    case ($urandom_range(0, 9)) inside
      [0:4]:   v = $urandom_range(0, 4095);
      5:       v = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(4093, 4095);
      6:       v = int'(cur_offset) + $urandom_range(0, 6) - 3;
      default: v = int'(prev) + $urandom_range(0, 16) - 8;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return SAMPLE_W'(v);
  endfunction

  // Long random stream in phases. Each phase starts from an idle block with
  // new settings; the first phases force the extreme windows, offsets and
  // every device code, and every third phase sends with no gaps at all.
  task automatic test_random_stream();
    int                  phase;
    int                  count;
    int                  burst_left;
    int unsigned         w;
    logic [SAMPLE_W-1:0] s;
    phase = 0;
    s = 12'd2048;
    while (samples_sent < SAMPLE_TARGET) begin
      wait_idle();
      case (phase)
        0:       w = 1;
        1:       w = MAX_WINDOW;
        2:       w = 0;
        3:       w = 63;
        default: w = $urandom_range(0, 63);
      endcase
      if (phase < 4 || $urandom_range(0, 3) != 0)
        write_reg(REG_WINDOW_SIZE, {6'($urandom), 6'(w)});
      case (phase % 5)
        0:       write_reg(REG_OFFSET_COUNTS, 12'd0);
        1:       write_reg(REG_OFFSET_COUNTS, 12'd4095);
        default: write_reg(REG_OFFSET_COUNTS, 12'($urandom));
      endcase
      write_reg(REG_DEVICE_TYPE, {10'($urandom), 2'(phase)});
      count = $urandom_range(60, 160);
      burst_left = 0;
      repeat (count) begin
        if (burst_left == 0) begin
          if (phase % 3 != 2) pause_sender($urandom_range(0, 12));
          burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s = next_sample(s);
        send_sample(s);
      end
      phase++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_warmup_at_reset();
    test_range_extremes();
    test_window_specials();
    test_random_stream();

    wait_idle();
    repeat (END_SLACK) @(posedge clk);
    if (pending_readings.size() != 0) begin
      $error("%0d readings never arrived", pending_readings.size());
      error_count++;
    end

    $display("Sent %0d samples and checked %0d pressure readings over %0d register writes,",
             samples_sent, readings_checked, config_writes);
    $display("covering warm-up, window wrap, all sensor ranges and back-pressure; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
